### src/assert_macros.svh
// Assertion macros shared by the streaming transpose RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds whenever the antecedent holds
`define SMT_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that a condition never holds
`define SMT_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        !(cond)) else $error(msg);

`endif

### src/smt_pkg.sv
// Types and constants shared by the streaming matrix transpose block
package smt_pkg;

    localparam int SIZE_W  = 7;
    localparam int COL_W   = 6;
    localparam int VALUE_W = 32;

    // Column job queue between front and back
    localparam int JOB_DEPTH = 4;
    localparam int JOB_PW    = $clog2(JOB_DEPTH);
    localparam int JOB_CW    = $clog2(JOB_DEPTH + 1);

    localparam logic KIND_SIZE    = 1'b0;
    localparam logic KIND_ELEMENT = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [SIZE_W-1:0]  matrix_size;
        logic [VALUE_W-1:0] element_value;
    } t_in;

    typedef struct packed {
        logic [VALUE_W-1:0] out_value;
        logic [COL_W-1:0]   out_column;
        logic               column_last;
    } t_out;

    // One column ready to stream out
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [SIZE_W-1:0] side;
    } t_job;

    // Store write request from the front
    typedef struct packed {
        logic               en;
        logic [COL_W-1:0]   col;
        logic [COL_W-1:0]   row;
        logic [VALUE_W-1:0] value;
    } t_wr_req;

endpackage

### src/smt_front.sv
// Front end: takes size and element requests, tracks position, issues store writes and jobs
module smt_front
    import smt_pkg::*;
#(
    parameter int MAX_SIDE = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_in     i_data,
    input  logic    i_back_idle,
    input  logic    i_job_full,
    output t_wr_req o_wr,
    output logic    o_push,
    output t_job    o_job
);

    localparam int IW  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SZW = $clog2(MAX_SIDE + 1);

    logic [SZW-1:0] r_size, n_size;
    logic [IW-1:0]  r_row, n_row;
    logic [IW-1:0]  r_col, n_col;
    logic           r_done, n_done;
    logic           r_same, n_same;

    logic           drop;
    logic           last_row;
    logic           last_col;
    logic           ok;
    logic           accept;
    logic [SZW-1:0] sat_size;

    // Classify the request at the head of the input
    always_comb begin
        drop     = r_done || (r_size == '0);
        last_row = (SZW'(r_row) == r_size - SZW'(1));
        last_col = (SZW'(r_col) == r_size - SZW'(1));
        if (i_data.matrix_size > SIZE_W'(MAX_SIDE)) begin
            sat_size = SZW'(MAX_SIDE);
        end else begin
            sat_size = SZW'(i_data.matrix_size);
        end
        // Hold an element while the back could still read what it overwrites
        if (i_data.kind == KIND_SIZE || drop) begin
            ok = 1'b1;
        end else begin
            ok = (i_back_idle || (r_same && last_row)) && (!last_row || !i_job_full);
        end
        accept = i_valid && ok;
    end

    assign o_stall = !ok;

    // Store write and column job
    always_comb begin
        o_wr.en    = accept && (i_data.kind == KIND_ELEMENT) && !drop;
        o_wr.col   = COL_W'(r_col);
        o_wr.row   = COL_W'(r_row);
        o_wr.value = i_data.element_value;
        o_push     = o_wr.en && last_row;
        o_job.col  = COL_W'(r_col);
        o_job.side = SIZE_W'(r_size);
    end

    // Advance the position counters
    always_comb begin
        n_size = r_size;
        n_row  = r_row;
        n_col  = r_col;
        n_done = r_done;
        n_same = r_same;
        if (accept && i_data.kind == KIND_SIZE) begin
            n_size = sat_size;
            n_row  = '0;
            n_col  = '0;
            n_done = (sat_size == '0);
            n_same = 1'b0;
        end else if (o_wr.en) begin
            if (last_row) begin
                n_same = 1'b1;
            end
            if (last_col) begin
                n_col = '0;
                if (last_row) begin
                    n_row  = '0;
                    n_done = 1'b1;
                end else begin
                    n_row = r_row + IW'(1);
                end
            end else begin
                n_col = r_col + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
            r_row  <= '0;
            r_col  <= '0;
            r_done <= 1'b1;
            r_same <= 1'b0;
        end else begin
            r_size <= n_size;
            r_row  <= n_row;
            r_col  <= n_col;
            r_done <= n_done;
            r_same <= n_same;
        end
    end

endmodule

### src/smt_job_fifo.sv
// Short queue of column jobs between the front and the back
module smt_job_fifo
    import smt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job              r_mem [JOB_DEPTH];
    logic [JOB_PW-1:0] r_wp, n_wp;
    logic [JOB_PW-1:0] r_rp, n_rp;
    logic [JOB_CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == JOB_CW'(JOB_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    // Move pointers and count
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = r_wp + JOB_PW'(1);
        end
        if (i_pop) begin
            n_rp = r_rp + JOB_PW'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + JOB_CW'(1);
            2'b01:   n_cnt = r_cnt - JOB_CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Hold job payloads
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

### src/smt_back.sv
// Back end: column store, column read-out and output buffer
module smt_back
    import smt_pkg::*;
#(
    parameter int MAX_SIDE   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_wr_req i_wr,
    input  t_job    i_job,
    input  logic    i_job_empty,
    output logic    o_pop,
    output logic    o_idle,
    output logic    o_valid,
    input  logic    i_stall,
    output t_out    o_data
);

    localparam int IW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SZW   = $clog2(MAX_SIDE + 1);
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = (MAX_SIDE > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_WIDTH-1:0] r_store [DEPTH];

    logic           r_busy, n_busy;
    logic [IW-1:0]  r_col, n_col;
    logic [IW-1:0]  r_row, n_row;
    logic [SZW-1:0] r_side, n_side;

    logic                  r_rd_v;
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic [COL_W-1:0]      r_rd_col;
    logic                  r_rd_last;

    t_out       r_ob [2];
    logic       r_ob_wp, r_ob_rp;
    logic [1:0] r_ob_cnt, n_ob_cnt;

    logic          issue;
    logic          is_last;
    logic          out_pop;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    t_out          ob_in;

    assign wr_addr = AW'(AW'(i_wr.col) * AW'(MAX_SIDE) + AW'(i_wr.row));
    assign rd_addr = AW'(AW'(r_col) * AW'(MAX_SIDE) + AW'(r_row));

    // Write the store and read one column entry a cycle while the output buffer has room
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_store[wr_addr] <= DATA_WIDTH'(i_wr.value);
        end
        if (issue) begin
            r_rd_data <= r_store[rd_addr];
        end
    end

    // Issue a read only when the output buffer will have room for it
    always_comb begin
        out_pop = o_valid && !i_stall;
        is_last = (SZW'(r_row) == r_side - SZW'(1));
        issue   = r_busy && (((r_ob_cnt + 2'(r_rd_v)) < 2'd2) || out_pop);
        o_pop   = !r_busy && !i_job_empty;
        o_idle  = !r_busy && i_job_empty;
    end

    // Step through the column, load the next job when free
    always_comb begin
        n_busy = r_busy;
        n_col  = r_col;
        n_row  = r_row;
        n_side = r_side;
        if (o_pop) begin
            n_busy = 1'b1;
            n_col  = IW'(i_job.col);
            n_row  = '0;
            n_side = SZW'(i_job.side);
        end else if (issue) begin
            if (is_last) begin
                n_busy = 1'b0;
            end else begin
                n_row = r_row + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rd_v <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_rd_v <= issue;
        end
        r_col  <= n_col;
        r_row  <= n_row;
        r_side <= n_side;
        if (issue) begin
            r_rd_col  <= COL_W'(r_col);
            r_rd_last <= is_last;
        end
    end

    // Output buffer of two entries
    always_comb begin
        ob_in.out_value   = VALUE_W'(r_rd_data);
        ob_in.out_column  = r_rd_col;
        ob_in.column_last = r_rd_last;
        case ({r_rd_v, out_pop})
            2'b10:   n_ob_cnt = r_ob_cnt + 2'd1;
            2'b01:   n_ob_cnt = r_ob_cnt - 2'd1;
            default: n_ob_cnt = r_ob_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wp  <= 1'b0;
            r_ob_rp  <= 1'b0;
            r_ob_cnt <= 2'd0;
        end else begin
            r_ob_cnt <= n_ob_cnt;
            if (r_rd_v) begin
                r_ob_wp <= !r_ob_wp;
            end
            if (out_pop) begin
                r_ob_rp <= !r_ob_rp;
            end
        end
        if (r_rd_v) begin
            r_ob[r_ob_wp] <= ob_in;
        end
    end

    assign o_valid = (r_ob_cnt != 2'd0);
    assign o_data  = r_ob[r_ob_rp];

endmodule

### src/streaming_matrix_transpose.sv
// Top level of the streaming matrix transpose block
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------
//   input    | in        | i_valid / o_stall  | i_data (t_in)
//   output   | out       | o_valid / i_stall  | o_data (t_out)
//
// Element and size requests are taken at one a cycle while the store is free.
// Each element of the last row starts a column of N results, streamed at one a
// cycle while the output is not stalled, by the single store read port; up to
// four columns queue up.
// The first element of a new matrix waits until the previous columns are out.
// Reset clears control only; the store needs no clearing pass.
`include "assert_macros.svh"

module streaming_matrix_transpose
    import smt_pkg::*;
#(
    parameter int MAX_SIDE   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    t_wr_req w_wr;
    t_job    w_push_job;
    t_job    w_pop_job;
    logic    w_push;
    logic    w_pop;
    logic    w_job_full;
    logic    w_job_empty;
    logic    w_back_idle;

    smt_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .i_back_idle (w_back_idle),
        .i_job_full  (w_job_full),
        .o_wr        (w_wr),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    smt_job_fifo u_jobs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_job_full),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_job_empty)
    );

    smt_back #(
        .MAX_SIDE   (MAX_SIDE),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (w_wr),
        .i_job       (w_pop_job),
        .i_job_empty (w_job_empty),
        .o_pop       (w_pop),
        .o_idle      (w_back_idle),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

    // Queue never overflows or underflows
    `SMT_ASSERT_NEVER(a_job_overflow, w_push && w_job_full, "job pushed into full queue")
    `SMT_ASSERT_NEVER(a_job_underflow, w_pop && w_job_empty, "job popped from empty queue")
    // A store write while columns are still out must complete a column
    `SMT_ASSERT_IMPLIES(a_write_safe, w_wr.en && !w_back_idle, w_push, "write during read-out")

endmodule

### bench/tb_streaming_matrix_transpose.sv
// Self-checking bench for the streaming matrix transpose: directed table, then random matrices
module tb_streaming_matrix_transpose
    import smt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE_MAX     = 64;
    localparam int WORD_W       = 32;
    localparam int TOTAL_ITEMS  = 370;
    localparam int TAIL_CYCLES  = SIDE_MAX * (SIDE_MAX + 2) + 200;
    localparam int RESET_CYCLES = 9;

    // One row of the directed table
    typedef struct {
        t_in  req;
        bit   typed;
        int   n_out;
        t_out res;
    } t_dir_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_in  i_data  = '0;
    logic o_stall;
    logic o_valid;
    t_out o_data;

    // Transposer state as the bench sees it
    logic [WORD_W-1:0] held_words [SIDE_MAX][SIDE_MAX];
    int side_n    = 0;
    int row_idx   = 0;
    int col_idx   = 0;
    bit idle_flag = 1'b1;

    t_out step_results [$];
    t_out transposed_q [$];
    t_dir_row directed_tab [$];

    int errors        = 0;
    int items_sent    = 0;
    int items_used    = 0;
    int items_dropped = 0;
    int results_seen  = 0;
    int columns_seen  = 0;
    bit send_calm     = 1'b0;
    bit recv_calm     = 1'b0;
    int stall_left    = 0;
    int recv_phase    = 0;

    streaming_matrix_transpose #(
        .MAX_SIDE   (SIDE_MAX),
        .DATA_WIDTH (WORD_W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [WORD_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return $urandom;
    endfunction

    function automatic t_in size_req(input int n);
        t_in r;
        r = '0;
        r.kind = KIND_SIZE;
        r.matrix_size = n[SIZE_W-1:0];
        r.element_value = $urandom;
        return r;
    endfunction

    function automatic t_in elem_req(input logic [WORD_W-1:0] v);
        t_in r;
        r = '0;
        r.kind = KIND_ELEMENT;
        r.matrix_size = SIZE_W'($urandom);
        r.element_value = v;
        return r;
    endfunction

    function automatic t_out col_res(input logic [WORD_W-1:0] v, input int c, input bit last);
        t_out r;
        r.out_value = v;
        r.out_column = c[COL_W-1:0];
        r.column_last = last;
        return r;
    endfunction

    function automatic void add_row(input t_in req, input bit typed, input int n_out,
                                    input t_out res);
        t_dir_row row;
        row.req = req;
        row.typed = typed;
        row.n_out = n_out;
        row.res = res;
        directed_tab.push_back(row);
    endfunction

    // Advance the transposer by one request; fill step_results, return 0 if dropped
    function automatic bit transpose_step(input t_in req);
        int n;
        step_results.delete();
        if (req.kind == KIND_SIZE) begin
            n = int'(req.matrix_size);
            if (n > SIDE_MAX) n = SIDE_MAX;
            side_n = n;
            row_idx = 0;
            col_idx = 0;
            idle_flag = (n == 0);
            return 1'b1;
        end
        if (idle_flag || side_n == 0) return 1'b0;
        held_words[col_idx][row_idx] = req.element_value;
        // last row: this element completes its column, so stream the column out
        if (row_idx == side_n - 1) begin
            for (int r = 0; r < side_n; r++)
                step_results.push_back(col_res(held_words[col_idx][r], col_idx, r == side_n - 1));
        end
        col_idx++;
        if (col_idx >= side_n) begin
            col_idx = 0;
            row_idx++;
            if (row_idx >= side_n) begin
                row_idx = 0;
                idle_flag = 1'b1;
            end
        end
        return 1'b1;
    endfunction

    // Offer one request, hold it until taken, then record what it should produce
    task automatic send_request(input t_in req, input bit typed, input int n_out,
                                input t_out res);
        int gap;
        if (items_sent % 40 == 0) send_calm = ($urandom_range(0, 2) == 0);
        gap = send_calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        if (transpose_step(req)) items_used++;
        else items_dropped++;
        if (typed) begin
            repeat (n_out) transposed_q.push_back(res);
        end else begin
            foreach (step_results[k]) transposed_q.push_back(step_results[k]);
        end
    endtask

    task automatic send_plain(input t_in req);
        send_request(req, 1'b0, 0, '0);
    endtask

    // Receiver back-pressure, with calm stretches
    always @(posedge i_clk) begin
        int n;
        recv_phase++;
        if (recv_phase % 256 == 0) recv_calm = ($urandom_range(0, 2) == 0);
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            n = recv_calm ? 0 : pick_gap();
            if (n > 0) begin
                stall_left = n - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Compare each taken result with the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (o_data.column_last) columns_seen++;
            if (transposed_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, got value %h column %0d last %b",
                         $time, o_data.out_value, o_data.out_column, o_data.column_last);
            end else begin
                want = transposed_q.pop_front();
                if (o_data.out_value !== want.out_value) begin
                    errors++;
                    $display("%0t: out_value mismatch: expected %h, got %h",
                             $time, want.out_value, o_data.out_value);
                end
                if (o_data.out_column !== want.out_column) begin
                    errors++;
                    $display("%0t: out_column mismatch: expected %0d, got %0d",
                             $time, want.out_column, o_data.out_column);
                end
                if (o_data.column_last !== want.column_last) begin
                    errors++;
                    $display("%0t: column_last mismatch: expected %b, got %b",
                             $time, want.column_last, o_data.column_last);
                end
            end
        end
    end

    // Stimulus
    initial begin
        int pick;
        int n;
        int count;
        bit drained;
        drained = 1'b0;

        // Elements with no matrix open, empty and unit matrices, two 2x2s, abandoned
        // matrices, an oversized side and the largest side
        add_row(elem_req(32'hDEAD_BEEF), 1'b1, 0, '0);
        add_row(size_req(0), 1'b1, 0, '0);
        add_row(elem_req(32'hFFFF_FFFF), 1'b1, 0, '0);
        add_row(size_req(1), 1'b1, 0, '0);
        add_row(elem_req(32'hFFFF_FFFF), 1'b1, 1, col_res(32'hFFFF_FFFF, 0, 1'b1));
        add_row(elem_req(32'h1234_5678), 1'b1, 0, '0);
        add_row(size_req(1), 1'b1, 0, '0);
        add_row(elem_req(32'h0000_0000), 1'b1, 1, col_res(32'h0000_0000, 0, 1'b1));
        add_row(size_req(2), 1'b1, 0, '0);
        add_row(elem_req(32'd1), 1'b0, 0, '0);
        add_row(elem_req(32'd2), 1'b0, 0, '0);
        add_row(elem_req(32'd3), 1'b0, 0, '0);
        add_row(elem_req(32'd4), 1'b0, 0, '0);
        add_row(size_req(3), 1'b1, 0, '0);
        add_row(elem_req(32'h0000_000A), 1'b0, 0, '0);
        add_row(elem_req(32'h0000_000B), 1'b0, 0, '0);
        add_row(elem_req(32'h0000_000C), 1'b0, 0, '0);
        add_row(size_req(2), 1'b1, 0, '0);
        add_row(elem_req(32'h8000_0000), 1'b0, 0, '0);
        add_row(elem_req(32'h7FFF_FFFF), 1'b0, 0, '0);
        add_row(elem_req(32'h5555_5555), 1'b0, 0, '0);
        add_row(elem_req(32'hAAAA_AAAA), 1'b0, 0, '0);
        add_row(size_req(127), 1'b1, 0, '0);
        add_row(elem_req(32'h0F0F_0F0F), 1'b1, 0, '0);
        add_row(size_req(64), 1'b1, 0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_tab[i])
            send_request(directed_tab[i].req, directed_tab[i].typed,
                         directed_tab[i].n_out, directed_tab[i].res);

        // Random part: mostly complete matrices with random content
        while (items_sent < TOTAL_ITEMS) begin
            // hold off once until every column has drained
            if (!drained && items_sent > TOTAL_ITEMS / 2) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (transposed_q.size() != 0) @(posedge i_clk);
                drained = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
                // keep the last matrices within the item budget
                while (n > 1 && n * n > TOTAL_ITEMS - items_sent) n--;
                send_plain(size_req(n));
                repeat (n * n) send_plain(elem_req(pick_value()));
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 2)) send_plain(elem_req(pick_value()));
            end else if (pick < 88) begin
                // abandon a matrix part way through
                n = $urandom_range(2, 8);
                send_plain(size_req(n));
                repeat ($urandom_range(1, n * n - 1)) send_plain(elem_req(pick_value()));
            end else if (pick < 93) begin
                // empty or oversized side
                if ($urandom_range(0, 1) == 0) begin
                    send_plain(size_req(0));
                    count = $urandom_range(1, 3);
                end else begin
                    send_plain(size_req($urandom_range(SIDE_MAX + 1, 127)));
                    count = $urandom_range(1, 80);
                end
                repeat (count) send_plain(elem_req(pick_value()));
            end else begin
                // stray elements
                repeat ($urandom_range(1, 4)) send_plain(elem_req(pick_value()));
            end
        end

        // Drop valid and drain
        i_valid <= 1'b0;
        while (transposed_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (transposed_q.size() != 0) begin
            errors++;
            $display("%0t: %0d results still expected at the end", $time, transposed_q.size());
        end

        $display("Covered %0d requests (%0d taken, %0d ignored) and %0d transposed values",
                 items_sent, items_used, items_dropped, results_seen);
        $display("in %0d columns, with empty, unit, abandoned and oversized matrices",
                 columns_seen);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #20_000_000;
        $display("%0t: timeout", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
